@@ src/hpos_pkg.sv @@
// hpos_pkg: shared types and constants for the huge page order select unit
// request/response payload structs, outcome codes, register indexes
// no dependencies
package hpos_pkg;

    localparam int ADDR_WIDTH    = 48;
    localparam int ORDER_MASK_W  = 10;
    localparam int ORDER_W       = 4;
    localparam int MIN_COUNT_W   = 10;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 10;
    localparam int MIN_ORDER     = 2;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_ENABLED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BLOCK_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXEC_BOOST_ON    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRY_RUN_ON       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_LOCAL_FIRST = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIFETIME_REDUCE  = 3'd5;

    typedef enum logic [2:0] {
        OUT_DISABLED   = 3'd0,
        OUT_EMPTY_MASK = 3'd1,
        OUT_TOO_SMALL  = 3'd2,
        OUT_AT_MAX     = 3'd3,
        OUT_MASK_EMPTY = 3'd4,
        OUT_APPLIED    = 3'd5,
        OUT_DRY_RUN    = 3'd6
    } t_outcome;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]   region_start;
        logic [ADDR_WIDTH-1:0]   region_end;
        logic                    is_exec_file;
        logic                    is_fresh_anon;
        logic                    is_locked;
        logic [ORDER_MASK_W-1:0] allowed_orders;
        logic [ORDER_MASK_W-1:0] local_avail;
        logic [ORDER_MASK_W-1:0] global_avail;
    } t_req;

    typedef struct packed {
        t_outcome                outcome;
        logic [ORDER_MASK_W-1:0] result_orders;
        logic [ORDER_W-1:0]      chosen_order;
        logic                    pressure_downgrade;
        logic                    remote_downgrade;
        logic                    lifetime_reduced;
    } t_rsp;

    // result of the fit / availability scan
    typedef struct packed {
        logic               found;
        logic [ORDER_W-1:0] sel;
        logic               pressure;
        logic               remote;
    } t_pick;

endpackage

@@ src/hpos_order_pick.sv @@
// hpos_order_pick: picks the largest fitting order, then walks down to the
// first order available globally or (with local first) locally; combinational
// depends on hpos_pkg
module hpos_order_pick #(
    parameter int MAX_ORDER_SEL = 9
) (
    input  logic [MAX_ORDER_SEL:hpos_pkg::MIN_ORDER]  i_fit,
    input  logic [hpos_pkg::ORDER_MASK_W-1:0]         i_local_avail,
    input  logic [hpos_pkg::ORDER_MASK_W-1:0]         i_global_avail,
    input  logic                                      i_node_local_first,
    output hpos_pkg::t_pick                           o_pick
);
    import hpos_pkg::*;

    localparam int NORD = MAX_ORDER_SEL + 1;

    logic [NORD-1:0]    local_ext;
    logic [NORD-1:0]    global_ext;
    logic [NORD-1:0]    avail_any;
    logic [ORDER_W-1:0] start_order;
    logic               start_found;
    logic               hit;
    logic               hit_remote;
    logic [ORDER_W-1:0] hit_order;

    always_comb begin
        local_ext  = NORD'(i_local_avail);
        global_ext = NORD'(i_global_avail);
        avail_any  = global_ext | (local_ext & {NORD{i_node_local_first}});

        // highest order that fits
        start_found = 1'b0;
        start_order = ORDER_W'(MIN_ORDER);
        for (int o = MIN_ORDER; o <= MAX_ORDER_SEL; o++) begin
            if (i_fit[o]) begin
                start_found = 1'b1;
                start_order = ORDER_W'(o);
            end
        end

        // highest available order at or below the start
        hit        = 1'b0;
        hit_remote = 1'b0;
        hit_order  = ORDER_W'(MIN_ORDER);
        for (int o = MIN_ORDER; o <= MAX_ORDER_SEL; o++) begin
            if ((ORDER_W'(o) <= start_order) && avail_any[o]) begin
                hit        = 1'b1;
                hit_order  = ORDER_W'(o);
                hit_remote = i_node_local_first & ~local_ext[o];
            end
        end

        o_pick.found = start_found;
        if (hit) begin
            o_pick.sel      = hit_order;
            o_pick.pressure = (hit_order != start_order);
            o_pick.remote   = hit_remote;
        end else begin
            // nothing available anywhere: fall back to the smallest order
            o_pick.sel      = ORDER_W'(MIN_ORDER);
            o_pick.pressure = 1'b1;
            o_pick.remote   = 1'b1;
        end
    end

endmodule

@@ src/huge_page_order_select_unit.sv @@
// huge_page_order_select_unit: five-stage pipeline choosing a huge page order
// for one memory region request
// depends on hpos_pkg and hpos_order_pick
//
// Usage: a request transaction (t_req) enters on i_in_valid / o_in_ready and
// one response transaction (t_rsp) leaves on o_out_valid / i_out_ready.
// Configuration registers are written on i_cfg_valid with i_cfg_index and
// i_cfg_data; o_cfg_ready is always high. Write them only while no request
// is in flight.
// The request passes five register stages (round-up of the start address
// per order, end minus aligned start, block count compare, order scan,
// boost / reduce / trim into the output register) before o_out_valid rises.
// Throughput: one request per cycle while the receiver is not stalling.
// Each stage holds its own valid bit, so bubbles close up when the receiver
// stalls; a full pipeline behind a stalled receiver drops o_in_ready.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with policy on, two blocks, exec boost on, dry run off, local
// first on and lifetime reduction on.
module huge_page_order_select_unit #(
    parameter int PAGE_BITS     = 12,
    parameter int MAX_ORDER_SEL = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hpos_pkg::t_req                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hpos_pkg::t_rsp                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hpos_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [hpos_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hpos_pkg::*;

    localparam int AW  = ADDR_WIDTH;
    localparam int AW1 = ADDR_WIDTH + 1;

    // configuration
    logic                   r_policy_enabled;
    logic [MIN_COUNT_W-1:0] r_min_block_count;
    logic                   r_exec_boost_on;
    logic                   r_dry_run_on;
    logic                   r_node_local_first;
    logic                   r_lifetime_reduce_on;

    // stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // stage 1
    logic [AW:0] n_s1_aligned [MAX_ORDER_SEL:MIN_ORDER];
    logic [AW:0] r_s1_aligned [MAX_ORDER_SEL:MIN_ORDER];
    logic        n_s1_early;
    t_outcome    n_s1_code;
    logic        r_s1_early;
    t_outcome    r_s1_code;
    t_req        r_s1_req;
    logic [AW:0] low_mask;

    // stage 2
    logic [AW-1:0]                  n_s2_diff [MAX_ORDER_SEL:MIN_ORDER];
    logic [AW-1:0]                  r_s2_diff [MAX_ORDER_SEL:MIN_ORDER];
    logic [MAX_ORDER_SEL:MIN_ORDER] n_s2_neg, r_s2_neg;
    logic [MAX_ORDER_SEL:MIN_ORDER] n_s2_ovf, r_s2_ovf;
    logic                           r_s2_early;
    t_outcome                       r_s2_code;
    t_req                           r_s2_req;
    logic [AW+1:0]                  diff_full;

    // stage 3
    logic [MAX_ORDER_SEL:MIN_ORDER] n_s3_fit, r_s3_fit;
    logic                           n_s3_small_ok;
    logic                           n_s3_early, r_s3_early;
    t_outcome                       n_s3_code, r_s3_code;
    t_req                           r_s3_req;
    logic [AW-1:0]                  quot;
    logic [AW-1:0]                  min_count_ext;

    // stage 4
    t_pick    n_s4_pick, r_s4_pick;
    logic     n_s4_early, r_s4_early;
    t_outcome n_s4_code, r_s4_code;
    t_req     r_s4_req;

    // stage 5
    t_rsp                    n_s5_rsp, r_s5_rsp;
    logic [ORDER_W-1:0]      sel;
    logic [ORDER_MASK_W-1:0] keep;
    logic [ORDER_MASK_W-1:0] trimmed;
    logic                    lred;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_enabled     <= 1'b1;
            r_min_block_count    <= MIN_COUNT_W'(2);
            r_exec_boost_on      <= 1'b1;
            r_dry_run_on         <= 1'b0;
            r_node_local_first   <= 1'b1;
            r_lifetime_reduce_on <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLICY_ENABLED:   r_policy_enabled     <= i_cfg_data[0];
                CFG_MIN_BLOCK_COUNT:  r_min_block_count    <= i_cfg_data;
                CFG_EXEC_BOOST_ON:    r_exec_boost_on      <= i_cfg_data[0];
                CFG_DRY_RUN_ON:       r_dry_run_on         <= i_cfg_data[0];
                CFG_NODE_LOCAL_FIRST: r_node_local_first   <= i_cfg_data[0];
                CFG_LIFETIME_REDUCE:  r_lifetime_reduce_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage moves when it is empty or the next one moves
    assign en5 = ~r_v5 | i_out_ready;
    assign en4 = ~r_v4 | en5;
    assign en3 = ~r_v3 | en4;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v5;
    assign o_out_data  = r_s5_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: round the start address up to each order's block size
    always_comb begin
        low_mask = '0;
        for (int o = MIN_ORDER; o <= MAX_ORDER_SEL; o++) begin
            low_mask        = (AW1'(1) << (PAGE_BITS + o)) - AW1'(1);
            n_s1_aligned[o] = ({1'b0, i_in_data.region_start} + low_mask) & ~low_mask;
        end
        n_s1_early = (i_in_data.allowed_orders == '0) | ~r_policy_enabled;
        n_s1_code  = (i_in_data.allowed_orders == '0) ? OUT_EMPTY_MASK : OUT_DISABLED;
    end

    // stage 2: room between aligned start and region end
    always_comb begin
        diff_full = '0;
        for (int o = MIN_ORDER; o <= MAX_ORDER_SEL; o++) begin
            diff_full    = {2'b00, r_s1_req.region_end} - {1'b0, r_s1_aligned[o]};
            n_s2_neg[o]  = diff_full[AW+1];
            n_s2_diff[o] = diff_full[AW-1:0];
            // aligned start past the address space
            n_s2_ovf[o]  = r_s1_aligned[o][AW];
        end
    end

    // stage 3: whole blocks in the room against the required count
    always_comb begin
        quot          = '0;
        min_count_ext = AW'(r_min_block_count);
        for (int o = MIN_ORDER; o <= MAX_ORDER_SEL; o++) begin
            quot        = r_s2_diff[o] >> (PAGE_BITS + o);
            n_s3_fit[o] = ~r_s2_ovf[o] & ~r_s2_neg[o] & (r_s2_diff[o] != '0)
                          & (quot >= min_count_ext);
        end
        // one order-2 block, end may equal the block end
        quot          = r_s2_diff[MIN_ORDER] >> (PAGE_BITS + MIN_ORDER);
        n_s3_small_ok = ~r_s2_ovf[MIN_ORDER] & ~r_s2_neg[MIN_ORDER] & (quot != '0);
        n_s3_early    = r_s2_early | ~n_s3_small_ok;
        n_s3_code     = r_s2_early ? r_s2_code : OUT_TOO_SMALL;
    end

    // stage 4: order scan
    hpos_order_pick #(
        .MAX_ORDER_SEL (MAX_ORDER_SEL)
    ) u_pick (
        .i_fit              (r_s3_fit),
        .i_local_avail      (r_s3_req.local_avail),
        .i_global_avail     (r_s3_req.global_avail),
        .i_node_local_first (r_node_local_first),
        .o_pick             (n_s4_pick)
    );

    always_comb begin
        n_s4_early = r_s3_early | ~n_s4_pick.found;
        n_s4_code  = r_s3_early ? r_s3_code : OUT_TOO_SMALL;
    end

    // stage 5: boost, lifetime reduction, mask trim and outcome
    always_comb begin
        sel     = r_s4_pick.sel;
        lred    = 1'b0;
        keep    = '0;
        trimmed = '0;

        n_s5_rsp.outcome            = r_s4_code;
        n_s5_rsp.result_orders      = r_s4_req.allowed_orders;
        n_s5_rsp.chosen_order       = '0;
        n_s5_rsp.pressure_downgrade = 1'b0;
        n_s5_rsp.remote_downgrade   = 1'b0;
        n_s5_rsp.lifetime_reduced   = 1'b0;

        if (!r_s4_early) begin
            if (r_s4_req.is_exec_file && r_exec_boost_on
                && (sel < ORDER_W'(MAX_ORDER_SEL))) begin
                sel = sel + ORDER_W'(1);
            end
            if (r_lifetime_reduce_on && r_s4_req.is_fresh_anon && !r_s4_req.is_locked
                && (sel > ORDER_W'(MIN_ORDER))) begin
                sel  = sel - ORDER_W'(1);
                lred = 1'b1;
            end
            for (int i = 0; i < ORDER_MASK_W; i++) begin
                keep[i] = (ORDER_W'(i) <= sel);
            end
            trimmed = r_s4_req.allowed_orders & keep;

            n_s5_rsp.chosen_order       = sel;
            n_s5_rsp.pressure_downgrade = r_s4_pick.pressure;
            n_s5_rsp.remote_downgrade   = r_s4_pick.remote;
            n_s5_rsp.lifetime_reduced   = lred;

            if (sel >= ORDER_W'(MAX_ORDER_SEL)) begin
                n_s5_rsp.outcome = OUT_AT_MAX;
            end else if (trimmed == '0) begin
                n_s5_rsp.outcome = OUT_MASK_EMPTY;
            end else if (r_dry_run_on) begin
                n_s5_rsp.outcome = OUT_DRY_RUN;
            end else begin
                n_s5_rsp.outcome       = OUT_APPLIED;
                n_s5_rsp.result_orders = trimmed;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_aligned <= n_s1_aligned;
            r_s1_early   <= n_s1_early;
            r_s1_code    <= n_s1_code;
            r_s1_req     <= i_in_data;
        end
        if (en2) begin
            r_s2_diff  <= n_s2_diff;
            r_s2_neg   <= n_s2_neg;
            r_s2_ovf   <= n_s2_ovf;
            r_s2_early <= r_s1_early;
            r_s2_code  <= r_s1_code;
            r_s2_req   <= r_s1_req;
        end
        if (en3) begin
            r_s3_fit   <= n_s3_fit;
            r_s3_early <= n_s3_early;
            r_s3_code  <= n_s3_code;
            r_s3_req   <= r_s2_req;
        end
        if (en4) begin
            r_s4_pick  <= n_s4_pick;
            r_s4_early <= n_s4_early;
            r_s4_code  <= n_s4_code;
            r_s4_req   <= r_s3_req;
        end
        if (en5) begin
            r_s5_rsp <= n_s5_rsp;
        end
    end

endmodule

@@ tb/sv/order_select_checker.sv @@
`timescale 1ns / 100ps
// order_select_checker: watches the request, response and register channels of
// huge_page_order_select_unit, predicts each response and compares it field by field
// depends on hpos_pkg
module order_select_checker #(
    parameter int PAGE_BITS = 12,
    parameter int TOP_ORDER = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  hpos_pkg::t_req                    i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  hpos_pkg::t_rsp                    i_out_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [hpos_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [hpos_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import hpos_pkg::*;

    localparam logic [63:0] ADDR_MAX = (64'd1 << ADDR_WIDTH) - 64'd1;

    // local copy of the policy registers
    logic                   policy_on;
    logic [MIN_COUNT_W-1:0] min_blocks;
    logic                   exec_boost;
    logic                   dry_run;
    logic                   local_first;
    logic                   life_reduce;

    t_rsp pending_choices[$];
    int   fails = 0;

    // true if count aligned blocks of 2^bits bytes fit in [base, stop); the first aligned
    // start must not wrap past the address space
    function automatic logic aligned_blocks_fit(input logic [63:0] base,
                                                input logic [63:0] stop,
                                                input int bits,
                                                input logic [63:0] count,
                                                input logic need_below);
        logic [63:0] size;
        logic [63:0] rem;
        logic [63:0] aligned;
        size    = 64'd1 << bits;
        rem     = base & (size - 64'd1);
        aligned = base;
        if (rem != 64'd0) begin
            if (base > ADDR_MAX - (size - rem))
                return 1'b0;
            aligned = base + (size - rem);
        end
        if (need_below ? (aligned >= stop) : (aligned > stop))
            return 1'b0;
        return (stop - aligned) >= count * size;
    endfunction

    function automatic t_rsp predict_order_choice(input t_req rq);
        t_rsp                    want;
        logic [63:0]             base;
        logic [63:0]             stop;
        logic [63:0]             need;
        logic [ORDER_MASK_W-1:0] keep;
        int                      ord;
        int                      sel;
        want               = '0;
        want.result_orders = rq.allowed_orders;
        base               = '0;
        stop               = '0;
        need               = '0;
        base[ADDR_WIDTH-1:0]  = rq.region_start;
        stop[ADDR_WIDTH-1:0]  = rq.region_end;
        need[MIN_COUNT_W-1:0] = min_blocks;
        if (rq.allowed_orders == '0) begin
            want.outcome = OUT_EMPTY_MASK;
        end else if (!policy_on) begin
            want.outcome = OUT_DISABLED;
        end else if (!aligned_blocks_fit(base, stop, PAGE_BITS + MIN_ORDER, 64'd1, 1'b0)) begin
            want.outcome = OUT_TOO_SMALL;
        end else begin
            ord = TOP_ORDER;
            while (ord >= MIN_ORDER &&
                   !aligned_blocks_fit(base, stop, PAGE_BITS + ord, need, 1'b1))
                ord--;
            if (ord < MIN_ORDER) begin
                want.outcome = OUT_TOO_SMALL;
            end else begin
                sel = -1;
                while (ord >= MIN_ORDER && sel < 0) begin
                    if (local_first && rq.local_avail[ord]) begin
                        sel = ord;
                    end else if (rq.global_avail[ord]) begin
                        want.remote_downgrade = local_first;
                        sel = ord;
                    end else begin
                        want.pressure_downgrade = 1'b1;
                        ord--;
                    end
                end
                // nothing free anywhere: fall back to the smallest huge order
                if (sel < 0) begin
                    want.pressure_downgrade = 1'b1;
                    want.remote_downgrade   = 1'b1;
                    sel = MIN_ORDER;
                end
                if (rq.is_exec_file && exec_boost && sel < TOP_ORDER)
                    sel++;
                if (life_reduce && rq.is_fresh_anon && !rq.is_locked && sel > MIN_ORDER) begin
                    sel--;
                    want.lifetime_reduced = 1'b1;
                end
                want.chosen_order = sel[ORDER_W-1:0];
                if (sel >= TOP_ORDER) begin
                    want.outcome = OUT_AT_MAX;
                end else begin
                    keep = ~('1 << (sel + 1));
                    if ((rq.allowed_orders & keep) == '0) begin
                        want.outcome = OUT_MASK_EMPTY;
                    end else if (dry_run) begin
                        want.outcome = OUT_DRY_RUN;
                    end else begin
                        want.outcome       = OUT_APPLIED;
                        want.result_orders = rq.allowed_orders & keep;
                    end
                end
            end
        end
        return want;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s expected %0h actual %0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            policy_on   = 1'b1;
            min_blocks  = MIN_COUNT_W'(2);
            exec_boost  = 1'b1;
            dry_run     = 1'b0;
            local_first = 1'b1;
            life_reduce = 1'b1;
            pending_choices.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_choices.size() == 0) begin
                    $error("response transaction with none outstanding, outcome %0d",
                           i_out_data.outcome);
                    fails++;
                end else begin
                    want = pending_choices.pop_front();
                    check_field("outcome", 16'(want.outcome), 16'(i_out_data.outcome));
                    check_field("result_orders", 16'(want.result_orders),
                                16'(i_out_data.result_orders));
                    check_field("chosen_order", 16'(want.chosen_order),
                                16'(i_out_data.chosen_order));
                    check_field("pressure_downgrade", 16'(want.pressure_downgrade),
                                16'(i_out_data.pressure_downgrade));
                    check_field("remote_downgrade", 16'(want.remote_downgrade),
                                16'(i_out_data.remote_downgrade));
                    check_field("lifetime_reduced", 16'(want.lifetime_reduced),
                                16'(i_out_data.lifetime_reduced));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_choices.push_back(predict_order_choice(i_in_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POLICY_ENABLED:   policy_on   = i_cfg_data[0];
                    CFG_MIN_BLOCK_COUNT:  min_blocks  = i_cfg_data[MIN_COUNT_W-1:0];
                    CFG_EXEC_BOOST_ON:    exec_boost  = i_cfg_data[0];
                    CFG_DRY_RUN_ON:       dry_run     = i_cfg_data[0];
                    CFG_NODE_LOCAL_FIRST: local_first = i_cfg_data[0];
                    CFG_LIFETIME_REDUCE:  life_reduce = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending    <= pending_choices.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/sv/tb_huge_page_order_select_unit.sv @@
`timescale 1ns / 100ps
// tb_huge_page_order_select_unit: clock, reset, request stimulus, register phases
// and the final verdict for huge_page_order_select_unit
// depends on hpos_pkg, huge_page_order_select_unit and order_select_checker
module tb_huge_page_order_select_unit;
    import hpos_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 7;
    localparam int          PAGE_BITS     = 12;
    localparam int          TOP_ORDER     = 9;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          HOLD_CYCLES   = 120;
    localparam int          DRAIN_SLACK   = 12;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam logic [63:0] ADDR_MAX      = (64'd1 << ADDR_WIDTH) - 64'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    t_req                   req_data = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    t_rsp                   rsp_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          fail_count;
    int          expected_left;
    int          tx_idle_pct = 34;
    int          rx_idle_pct = 34;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          cur_min_blocks = 2;
    int unsigned cycle_count = 0;

    huge_page_order_select_unit #(
        .PAGE_BITS     (PAGE_BITS),
        .MAX_ORDER_SEL (TOP_ORDER)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    order_select_checker #(
        .PAGE_BITS (PAGE_BITS),
        .TOP_ORDER (TOP_ORDER)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_ready   (req_ready),
        .i_in_data    (req_data),
        .i_out_valid  (rsp_valid),
        .i_out_ready  (rsp_ready),
        .i_out_data   (rsp_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (expected_left)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // response side: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk) begin
        if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            rsp_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_req mk_req(input logic [63:0] base, input logic [63:0] stop,
                                    input logic [2:0] kind,
                                    input logic [ORDER_MASK_W-1:0] allowed,
                                    input logic [ORDER_MASK_W-1:0] near,
                                    input logic [ORDER_MASK_W-1:0] anywhere);
        t_req rq;
        rq.region_start   = base[ADDR_WIDTH-1:0];
        rq.region_end     = stop[ADDR_WIDTH-1:0];
        rq.is_exec_file   = kind[2];
        rq.is_fresh_anon  = kind[1];
        rq.is_locked      = kind[0];
        rq.allowed_orders = allowed;
        rq.local_avail    = near;
        rq.global_avail   = anywhere;
        return rq;
    endfunction

    function automatic logic [ORDER_MASK_W-1:0] random_avail();
        logic [31:0] bits;
        bits = $urandom;
        case (bits[2:0])
            3'd0:    return '0;
            3'd1:    return '1;
            default: return bits[ORDER_MASK_W+2:3];
        endcase
    endfunction

    // mostly regions sized around the current block count, the rest near the
    // top of the address space, reversed or fully random
    function automatic t_req random_req();
        t_req        rq;
        logic [63:0] base;
        logic [63:0] stop;
        logic [63:0] span;
        logic [63:0] reach;
        logic [31:0] bits;
        int          pick;
        int          ord;
        int          zeros;
        pick  = $urandom_range(99);
        ord   = $urandom_range(TOP_ORDER + 1);
        base  = {$urandom, $urandom};
        reach = 64'(cur_min_blocks + 2);
        reach = reach << (PAGE_BITS + ord);
        span  = {$urandom, $urandom} % (reach + 64'd1);
        if (pick < 65) begin
            zeros = $urandom_range(PAGE_BITS + TOP_ORDER + 1);
            base  = base & ~((64'd1 << zeros) - 64'd1);
            stop  = base + span;
        end else if (pick < 75) begin
            base = ADDR_MAX - 64'($urandom_range(32'h0040_0000));
            stop = ($urandom_range(1) != 0) ? ADDR_MAX : base + span;
        end else if (pick < 85) begin
            stop = base - span;
        end else begin
            stop = {$urandom, $urandom};
        end
        bits = $urandom;
        rq.region_start   = base[ADDR_WIDTH-1:0];
        rq.region_end     = stop[ADDR_WIDTH-1:0];
        rq.is_exec_file   = bits[0];
        rq.is_fresh_anon  = bits[1];
        rq.is_locked      = bits[2] & bits[3];
        rq.allowed_orders = (bits[8:4] == 5'd0) ? '0 : bits[31:32-ORDER_MASK_W];
        rq.local_avail    = random_avail();
        rq.global_avail   = random_avail();
        return rq;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back items
    task automatic send_req(input t_req rq);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == CFG_MIN_BLOCK_COUNT)
            cur_min_blocks = int'(value);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    initial begin : stimulus
        int          phase;
        int          n;
        logic [31:0] bits;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                bits = $urandom;
                case (phase)
                    1: begin
                        write_reg(CFG_POLICY_ENABLED, 10'd1);
                        write_reg(CFG_MIN_BLOCK_COUNT, 10'd0);
                        write_reg(CFG_EXEC_BOOST_ON, 10'd0);
                        write_reg(CFG_DRY_RUN_ON, 10'd1);
                        write_reg(CFG_NODE_LOCAL_FIRST, 10'd0);
                        write_reg(CFG_LIFETIME_REDUCE, 10'd0);
                    end
                    2: begin
                        write_reg(CFG_MIN_BLOCK_COUNT, 10'd512);
                        write_reg(CFG_EXEC_BOOST_ON, 10'd1);
                        write_reg(CFG_DRY_RUN_ON, 10'd0);
                        write_reg(CFG_NODE_LOCAL_FIRST, 10'd1);
                        write_reg(CFG_LIFETIME_REDUCE, 10'd1);
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                    3: begin
                        write_reg(CFG_MIN_BLOCK_COUNT, 10'd1);
                        tx_idle_pct = 34;
                        rx_idle_pct = 34;
                    end
                    4: begin
                        write_reg(CFG_POLICY_ENABLED, 10'd0);
                    end
                    default: begin
                        // upper data bits are don't-care for the one-bit registers
                        write_reg(CFG_POLICY_ENABLED, {bits[9:1], 1'b1});
                        write_reg(CFG_MIN_BLOCK_COUNT, 10'($urandom_range(6)));
                        write_reg(CFG_EXEC_BOOST_ON, bits[19:10]);
                        write_reg(CFG_DRY_RUN_ON, {bits[29:21], bits[20] & bits[30]});
                        write_reg(CFG_NODE_LOCAL_FIRST, bits[10:1]);
                        write_reg(CFG_LIFETIME_REDUCE, bits[21:12]);
                        if (phase == 5)
                            write_reg(CFG_SPARE_INDEX, bits[31:22]);
                    end
                endcase
            end

            if (phase == 0) begin
                send_req(mk_req(64'h0, 64'h40_0000, 3'b000, 10'h000, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h0, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h4000, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h1000, 64'h40_0000, 3'b000, 10'h3FF, 10'h020, 10'h080));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b000, 10'h3FF, 10'h000, 10'h000));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b100, 10'h3FF, 10'h100, 10'h100));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b010, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b011, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h10_0000, 3'b000, 10'h300, 10'h3FF, 10'h3FF));
                send_req(mk_req(ADDR_MAX - 64'd5, ADDR_MAX, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(ADDR_MAX, ADDR_MAX, 3'b111, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h80_0000, 64'h1000, 3'b000, 10'h3FF, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h40_0000, 3'b000, 10'h001, 10'h3FF, 10'h3FF));
                send_req(mk_req(64'h0, 64'h80_0000, 3'b110, 10'h200, 10'h008, 10'h3FF));
            end else if (phase == 1) begin
                // zero block count: an aligned start just below the end is enough
                send_req(mk_req(64'h1000, 64'h20_1000, 3'b000, 10'h3FF, 10'h000, 10'h3FF));
                send_req(mk_req(64'h1000, 64'h10_1000, 3'b000, 10'h3FF, 10'h000, 10'h0C0));
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold the response side off so the pipeline fills and backs up
                if (phase == 3 && n == 30)
                    hold_requests++;
                send_req(random_req());
            end
        end

        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
